FILE: src/odg_pkg.sv
package odg_pkg;

    localparam int DIST_W  = 16;
    localparam int SCALE_W = 10;
    localparam int TIME_W  = 32;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // dividend is a (scale gap x distance over stop) product
    localparam int PROD_W    = 2 * DIST_W;
    localparam int DIV_STEPS = PROD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [DIST_W-1:0] INVALID_DISTANCE = 16'hFFFF;
    localparam logic [DIST_W-1:0] FULL_SCALE       = 16'd1000;

    localparam logic [DIST_W-1:0]  RST_STOP_DISTANCE   = 16'd300;
    localparam logic [DIST_W-1:0]  RST_SLOW_DISTANCE   = 16'd1000;
    localparam logic [DIST_W-1:0]  RST_HYST_DISTANCE   = 16'd100;
    localparam logic [SCALE_W-1:0] RST_MINIMUM_SCALE   = 10'd200;
    localparam logic [TIME_W-1:0]  RST_INVALID_TIMEOUT = 32'd500;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_STOP_DISTANCE   = 3'd0;
    localparam logic [2:0] REG_SLOW_DISTANCE   = 3'd1;
    localparam logic [2:0] REG_HYST_DISTANCE   = 3'd2;
    localparam logic [2:0] REG_MINIMUM_SCALE   = 3'd3;
    localparam logic [2:0] REG_INVALID_TIMEOUT = 3'd4;

    typedef enum logic [1:0] {
        LV_CLEAR = 2'd0,
        LV_SLOW  = 2'd1,
        LV_STOP  = 2'd2,
        LV_FAIL  = 2'd3
    } level_t;

    typedef struct packed {
        logic [DIST_W-1:0]  stop_distance;
        logic [DIST_W-1:0]  slow_distance;
        logic [DIST_W-1:0]  hysteresis_distance;
        logic [SCALE_W-1:0] minimum_scale;
        logic [TIME_W-1:0]  invalid_timeout;
    } cfg_t;

    typedef struct packed {
        logic load_in;
        logic eval;
        logic mul;
        logic div_step;
        logic finish;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic need_div;
    } status_t;

endpackage

FILE: src/odg_ctrl.sv
module odg_ctrl
    import odg_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EVAL = 6'b000010,
        S_MUL  = 6'b000100,
        S_DIV  = 6'b001000,
        S_FIN  = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;
    logic             out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = status.need_div ? S_MUL : S_OUT;
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

FILE: src/odg_datapath.sv
module odg_datapath
    import odg_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  cmd_t               cmd,
    output status_t            status,
    input  logic [DIST_W-1:0]  s_distance,
    input  logic               s_echo_ok,
    input  logic [TIME_W-1:0]  s_time_ms,
    output logic [1:0]         m_level,
    output logic [SCALE_W-1:0] m_speed_scale,
    output logic [DIST_W-1:0]  m_reported_distance,
    output logic               m_reading_valid
);

    // captured request
    logic [DIST_W-1:0]  in_dist_reg;
    logic               in_ok_reg;
    logic [TIME_W-1:0]  in_time_reg;

    // grading state
    logic [TIME_W-1:0]  invalid_since_reg;
    logic               invalid_run_reg;
    logic               stopped_reg;
    level_t             held_level_reg;
    logic [SCALE_W-1:0] held_scale_reg;
    logic [DIST_W-1:0]  held_dist_reg;
    logic               held_valid_reg;

    // divider
    logic [PROD_W-1:0]  quo_reg;
    logic [DIST_W-1:0]  rem_reg;
    logic [DIST_W-1:0]  divisor_reg;

    // result register
    level_t             out_level_reg;
    logic [SCALE_W-1:0] out_scale_reg;
    logic [DIST_W-1:0]  out_dist_reg;
    logic               out_valid_reg;

    logic               is_invalid;
    logic [TIME_W-1:0]  since_eff;
    logic [TIME_W-1:0]  elapsed;
    logic               expired;
    logic [DIST_W-1:0]  exit_mm;
    logic               hold_stop;
    logic               above_slow;
    logic               above_stop;
    logic [DIST_W-1:0]  smin_ext;
    logic [DIST_W-1:0]  smin_sat;
    logic [DIST_W-1:0]  scale_gap;
    logic [DIST_W-1:0]  over;
    logic [DIST_W-1:0]  span;
    logic [PROD_W-1:0]  product;
    logic [DIST_W:0]    rem_shift;
    logic               div_ge;
    logic [PROD_W:0]    scale_sum;
    logic [DIST_W-1:0]  scale_clamped;

    assign is_invalid = !in_ok_reg || (in_dist_reg == INVALID_DISTANCE);
    assign since_eff  = invalid_run_reg ? invalid_since_reg : in_time_reg;
    assign elapsed    = in_time_reg - since_eff;
    assign expired    = (elapsed >= cfg.invalid_timeout);

    assign exit_mm    = cfg.stop_distance + cfg.hysteresis_distance;
    assign hold_stop  = stopped_reg && (in_dist_reg <= exit_mm);
    assign above_slow = (in_dist_reg > cfg.slow_distance);
    assign above_stop = (in_dist_reg > cfg.stop_distance);

    assign status.need_div = !is_invalid && !hold_stop && !above_slow && above_stop;

    assign smin_ext  = DIST_W'(cfg.minimum_scale);
    assign smin_sat  = (smin_ext > FULL_SCALE) ? FULL_SCALE : smin_ext;
    assign scale_gap = FULL_SCALE - smin_sat;
    assign over      = in_dist_reg - cfg.stop_distance;
    assign span      = cfg.slow_distance - cfg.stop_distance;
    assign product   = PROD_W'(scale_gap) * PROD_W'(over);

    // restoring division, one quotient bit per cycle
    assign rem_shift = {rem_reg, quo_reg[PROD_W-1]};
    assign div_ge    = (rem_shift >= {1'b0, divisor_reg});

    assign scale_sum     = (PROD_W + 1)'(smin_sat) + (PROD_W + 1)'(quo_reg);
    assign scale_clamped = (scale_sum > (PROD_W + 1)'(FULL_SCALE)) ? FULL_SCALE
                                                                  : scale_sum[DIST_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_dist_reg <= s_distance;
            in_ok_reg   <= s_echo_ok;
            in_time_reg <= s_time_ms;
        end
        if (cmd.mul) begin
            quo_reg     <= product;
            rem_reg     <= '0;
            divisor_reg <= span;
        end else if (cmd.div_step) begin
            quo_reg <= {quo_reg[PROD_W-2:0], div_ge};
            rem_reg <= div_ge ? DIST_W'(rem_shift - {1'b0, divisor_reg})
                              : rem_shift[DIST_W-1:0];
        end
        if (cmd.load_out) begin
            out_level_reg <= held_level_reg;
            out_scale_reg <= held_scale_reg;
            out_dist_reg  <= held_dist_reg;
            out_valid_reg <= held_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            invalid_since_reg <= '0;
            invalid_run_reg   <= 1'b0;
            stopped_reg       <= 1'b0;
            held_level_reg    <= LV_CLEAR;
            held_scale_reg    <= '0;
            held_dist_reg     <= '0;
            held_valid_reg    <= 1'b0;
        end else if (cmd.eval) begin
            if (is_invalid) begin
                if (!invalid_run_reg) begin
                    invalid_run_reg   <= 1'b1;
                    invalid_since_reg <= in_time_reg;
                end
                if (expired) begin
                    held_level_reg <= LV_FAIL;
                    held_scale_reg <= '0;
                    held_dist_reg  <= INVALID_DISTANCE;
                    held_valid_reg <= 1'b0;
                    stopped_reg    <= 1'b1;
                end
            end else begin
                invalid_run_reg <= 1'b0;
                held_valid_reg  <= 1'b1;
                held_dist_reg   <= in_dist_reg;
                if (hold_stop) begin
                    held_level_reg <= LV_STOP;
                    held_scale_reg <= '0;
                end else if (above_slow) begin
                    stopped_reg    <= 1'b0;
                    held_level_reg <= LV_CLEAR;
                    held_scale_reg <= FULL_SCALE[SCALE_W-1:0];
                end else if (above_stop) begin
                    // level and scale land when the divider finishes
                    stopped_reg <= 1'b0;
                end else begin
                    stopped_reg    <= 1'b1;
                    held_level_reg <= LV_STOP;
                    held_scale_reg <= '0;
                end
            end
        end else if (cmd.finish) begin
            held_level_reg <= LV_SLOW;
            held_scale_reg <= scale_clamped[SCALE_W-1:0];
        end
    end

    assign m_level             = out_level_reg;
    assign m_speed_scale       = out_scale_reg;
    assign m_reported_distance = out_dist_reg;
    assign m_reading_valid     = out_valid_reg;

endmodule

FILE: src/obstacle_distance_grader_unit.sv
// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+------------------------------------------
// s_        | in        | s_valid / s_ready  | s_distance, s_echo_ok, s_time_ms
// m_        | out       | m_valid / m_ready  | m_level, m_speed_scale,
//           |           |                    | m_reported_distance, m_reading_valid
// APB       | in/out    | psel/penable/pready| paddr, pwrite, pwdata, prdata
//
// A clear, stop or invalid request passes the accept, grade and output load
// states. A slow-band request also passes a multiply state, a 32-step
// restoring divider (one quotient bit per cycle) and a finish state before
// the output load.
// Reset (aresetn low, synchronous) clears the grade state and the FSM;
// config registers return to their default thresholds.
// The next request is taken once the previous result sits in the output
// register; it is graded while that result waits, then holds in the output
// state (s_ready low) until m_ready frees the register.
module obstacle_distance_grader_unit
    import odg_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    // reading channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [DIST_W-1:0]  s_distance,
    input  logic               s_echo_ok,
    input  logic [TIME_W-1:0]  s_time_ms,

    // grade channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_level,
    output logic [SCALE_W-1:0] m_speed_scale,
    output logic [DIST_W-1:0]  m_reported_distance,
    output logic               m_reading_valid,

    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       cfg_wr;
    logic [2:0] reg_idx;
    cmd_t       cmd;
    status_t    status;

    // ---- APB register file ----
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr) begin
            case (reg_idx)
                REG_STOP_DISTANCE:   cfg_next.stop_distance       = pwdata[DIST_W-1:0];
                REG_SLOW_DISTANCE:   cfg_next.slow_distance       = pwdata[DIST_W-1:0];
                REG_HYST_DISTANCE:   cfg_next.hysteresis_distance = pwdata[DIST_W-1:0];
                REG_MINIMUM_SCALE:   cfg_next.minimum_scale       = pwdata[SCALE_W-1:0];
                REG_INVALID_TIMEOUT: cfg_next.invalid_timeout     = pwdata[TIME_W-1:0];
                default: begin
                    // unmapped: write dropped
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_STOP_DISTANCE:   prdata = DATA_W'(cfg_reg.stop_distance);
            REG_SLOW_DISTANCE:   prdata = DATA_W'(cfg_reg.slow_distance);
            REG_HYST_DISTANCE:   prdata = DATA_W'(cfg_reg.hysteresis_distance);
            REG_MINIMUM_SCALE:   prdata = DATA_W'(cfg_reg.minimum_scale);
            REG_INVALID_TIMEOUT: prdata = DATA_W'(cfg_reg.invalid_timeout);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.stop_distance       <= RST_STOP_DISTANCE;
            cfg_reg.slow_distance       <= RST_SLOW_DISTANCE;
            cfg_reg.hysteresis_distance <= RST_HYST_DISTANCE;
            cfg_reg.minimum_scale       <= RST_MINIMUM_SCALE;
            cfg_reg.invalid_timeout     <= RST_INVALID_TIMEOUT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // ---- sequencer ----
    odg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // ---- grading datapath: compares, multiplier, serial divider ----
    odg_datapath u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg                 (cfg_reg),
        .cmd                 (cmd),
        .status              (status),
        .s_distance          (s_distance),
        .s_echo_ok           (s_echo_ok),
        .s_time_ms           (s_time_ms),
        .m_level             (m_level),
        .m_speed_scale       (m_speed_scale),
        .m_reported_distance (m_reported_distance),
        .m_reading_valid     (m_reading_valid)
    );

endmodule

FILE: src/odg_checker.sv
module odg_checker
    import odg_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic [1:0]         m_level,
    input logic [SCALE_W-1:0] m_speed_scale,
    input logic [DIST_W-1:0]  m_reported_distance,
    input logic               m_reading_valid
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_level) && $stable(m_speed_scale)
                                && $stable(m_reported_distance))
        else $error("stalled result changed");

    // fail grade carries the invalid marker and zero speed
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_level == LV_FAIL) |->
            (m_reported_distance == INVALID_DISTANCE) && !m_reading_valid
            && (m_speed_scale == '0))
        else $error("fail grade payload wrong");

    // stop grade means zero speed
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_level == LV_STOP) |-> (m_speed_scale == '0))
        else $error("stop grade with nonzero speed");

    // a clear grade from a valid reading is full speed
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_reading_valid && (m_level == LV_CLEAR) |->
            (m_speed_scale == FULL_SCALE[SCALE_W-1:0]))
        else $error("clear grade below full speed");

    // no result right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind obstacle_distance_grader_unit odg_checker u_odg_checker (
    .aclk                (aclk),
    .aresetn             (aresetn),
    .m_valid             (m_valid),
    .m_ready             (m_ready),
    .m_level             (m_level),
    .m_speed_scale       (m_speed_scale),
    .m_reported_distance (m_reported_distance),
    .m_reading_valid     (m_reading_valid)
);

FILE: bench/tb_top.sv
module tb_top
    import odg_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // The run ends here no matter what.
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    // Drain time after the last phase, so any straggling grade can still arrive.
    localparam int          DRAIN_CYCLES  = 80;
    localparam int          RANDOM_PHASES = 12;
    localparam int          PHASE_ITEMS   = 135;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              echo_ok;
        logic [TIME_W-1:0] time_ms;
    } reading_t;

    typedef struct packed {
        level_t             level;
        logic [SCALE_W-1:0] speed_scale;
        logic [DIST_W-1:0]  distance;
        logic               valid;
    } grade_t;

    logic               aclk;
    logic               aresetn = 1'b0;

    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [DIST_W-1:0]  s_distance = '0;
    logic               s_echo_ok = 1'b0;
    logic [TIME_W-1:0]  s_time_ms = '0;

    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [1:0]         m_level;
    logic [SCALE_W-1:0] m_speed_scale;
    logic [DIST_W-1:0]  m_reported_distance;
    logic               m_reading_valid;

    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]  pwdata = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    obstacle_distance_grader_unit i_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_distance          (s_distance),
        .s_echo_ok           (s_echo_ok),
        .s_time_ms           (s_time_ms),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_level             (m_level),
        .m_speed_scale       (m_speed_scale),
        .m_reported_distance (m_reported_distance),
        .m_reading_valid     (m_reading_valid),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    // ------------------------------------------------------------------
    // Grader state as the bench sees it. Thresholds start at the reset
    // defaults and follow every register write.
    // ------------------------------------------------------------------
    cfg_t   grader_cfg = '{
        stop_distance:       RST_STOP_DISTANCE,
        slow_distance:       RST_SLOW_DISTANCE,
        hysteresis_distance: RST_HYST_DISTANCE,
        minimum_scale:       RST_MINIMUM_SCALE,
        invalid_timeout:     RST_INVALID_TIMEOUT
    };
    logic              run_open     = 1'b0;   // inside a run of invalid readings
    logic [TIME_W-1:0] run_start    = '0;     // timestamp of the run's first reading
    logic              stop_latched = 1'b0;
    grade_t            held_grade   = '{level: LV_CLEAR, speed_scale: '0, distance: '0,
                                        valid: 1'b0};

    reading_t reading_q[$];   // requests waiting for the driver
    grade_t   grade_q[$];     // grades owed by the block, oldest first

    int          mismatches     = 0;
    int          readings_sent  = 0;
    int          readings_taken = 0;
    int          grades_taken   = 0;
    int          grades_seen    = 0;
    int          send_gap       = 0;
    int          stall_left     = 0;
    int unsigned cycle_count    = 0;
    bit          steady         = 1'b0;   // no idling on either side while set

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic note_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH: %s", msg);
    endtask

    // Grades one reading and advances the bench copy of the state.
    function automatic grade_t grade_reading(input reading_t rd);
        logic [TIME_W-1:0] elapsed;
        logic [DIST_W-1:0] exit_mm;
        logic              stays_stopped;
        logic [31:0]       smin;
        logic [31:0]       span;
        logic [31:0]       over;
        logic [31:0]       sc;

        stays_stopped = 1'b0;
        if (!rd.echo_ok || rd.distance == INVALID_DISTANCE) begin
            if (!run_open) begin
                run_open  = 1'b1;
                run_start = rd.time_ms;
            end
            elapsed = rd.time_ms - run_start;
            if (elapsed >= grader_cfg.invalid_timeout) begin
                held_grade.level       = LV_FAIL;
                held_grade.speed_scale = '0;
                held_grade.distance    = INVALID_DISTANCE;
                held_grade.valid       = 1'b0;
                stop_latched           = 1'b1;
            end
        end else begin
            run_open            = 1'b0;
            held_grade.valid    = 1'b1;
            held_grade.distance = rd.distance;
            if (stop_latched) begin
                // exit threshold wraps at 16 bits
                exit_mm = grader_cfg.stop_distance + grader_cfg.hysteresis_distance;
                if (rd.distance > exit_mm) begin
                    stop_latched = 1'b0;
                end else begin
                    stays_stopped = 1'b1;
                end
            end
            if (stays_stopped) begin
                held_grade.level       = LV_STOP;
                held_grade.speed_scale = '0;
            end else if (rd.distance > grader_cfg.slow_distance) begin
                held_grade.level       = LV_CLEAR;
                held_grade.speed_scale = FULL_SCALE[SCALE_W-1:0];
            end else if (rd.distance > grader_cfg.stop_distance) begin
                smin = 32'(grader_cfg.minimum_scale);
                if (smin > 32'(FULL_SCALE)) begin
                    smin = 32'(FULL_SCALE);
                end
                span = 32'(grader_cfg.slow_distance) - 32'(grader_cfg.stop_distance);
                over = 32'(rd.distance) - 32'(grader_cfg.stop_distance);
                if (span == 0) begin
                    sc = 32'(FULL_SCALE);
                end else begin
                    sc = smin + ((32'(FULL_SCALE) - smin) * over) / span;
                end
                if (sc > 32'(FULL_SCALE)) begin
                    sc = 32'(FULL_SCALE);
                end
                held_grade.level       = LV_SLOW;
                held_grade.speed_scale = sc[SCALE_W-1:0];
            end else begin
                held_grade.level       = LV_STOP;
                held_grade.speed_scale = '0;
                stop_latched           = 1'b1;
            end
        end
        return held_grade;
    endfunction

    task automatic add_reading(input logic [DIST_W-1:0] d, input logic ok,
                               input logic [TIME_W-1:0] t);
        reading_t rd;
        rd.distance = d;
        rd.echo_ok  = ok;
        rd.time_ms  = t;
        reading_q.push_back(rd);
    endtask

    // APB read of one register, compared with the bench copy.
    task automatic check_reg(input logic [2:0] idx);
        logic [DATA_W-1:0] want;
        case (idx)
            REG_STOP_DISTANCE:   want = DATA_W'(grader_cfg.stop_distance);
            REG_SLOW_DISTANCE:   want = DATA_W'(grader_cfg.slow_distance);
            REG_HYST_DISTANCE:   want = DATA_W'(grader_cfg.hysteresis_distance);
            REG_MINIMUM_SCALE:   want = DATA_W'(grader_cfg.minimum_scale);
            REG_INVALID_TIMEOUT: want = DATA_W'(grader_cfg.invalid_timeout);
            default:             want = '0;
        endcase
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_W'({idx, 2'b00});
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== want) begin
            note_mismatch($sformatf("register %0d reads %0h, expected %0h", idx, prdata, want));
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // APB write; mapped registers are read back afterwards.
    task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_STOP_DISTANCE:   grader_cfg.stop_distance       = value[DIST_W-1:0];
            REG_SLOW_DISTANCE:   grader_cfg.slow_distance       = value[DIST_W-1:0];
            REG_HYST_DISTANCE:   grader_cfg.hysteresis_distance = value[DIST_W-1:0];
            REG_MINIMUM_SCALE:   grader_cfg.minimum_scale       = value[SCALE_W-1:0];
            REG_INVALID_TIMEOUT: grader_cfg.invalid_timeout     = value[TIME_W-1:0];
            default: ;   // unmapped index, nothing changes
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx <= REG_INVALID_TIMEOUT) begin
            check_reg(idx);
        end
    endtask

    // Every request queued, accepted and answered: the block is idle.
    task automatic wait_idle();
        while (!(reading_q.size() == 0 && readings_taken == readings_sent &&
                 grade_q.size() == 0)) begin
            @(posedge aclk);
        end
    endtask

    // ------------------------------------------------------------------
    // Request driver. Payload and valid change only on the falling edge.
    // A request stays up until the sampler below has counted it as taken;
    // then the gap drawn for it runs out before the next one goes up. With
    // no gap the next request replaces the old one in the same assignment.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin : request_driver
        reading_t nxt;
        if (aresetn) begin
            if (s_valid && readings_taken != readings_sent) begin
                // still waiting for s_ready
            end else if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (reading_q.size() != 0) begin
                nxt = reading_q.pop_front();
                s_distance <= nxt.distance;
                s_echo_ok  <= nxt.echo_ok;
                s_time_ms  <= nxt.time_ms;
                s_valid    <= 1'b1;
                readings_sent++;
                send_gap = steady ? 0 : $urandom_range(0, 5);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Accepted requests are graded on the spot; the grade is owed later.
    always @(posedge aclk) begin : request_sampler
        reading_t rd;
        if (aresetn && s_valid && s_ready) begin
            rd.distance = s_distance;
            rd.echo_ok  = s_echo_ok;
            rd.time_ms  = s_time_ms;
            grade_q.push_back(grade_reading(rd));
            readings_taken++;
        end
    end

    // Result side back-pressure: a fresh stall is drawn after every grade.
    always @(negedge aclk) begin : ready_driver
        if (aresetn) begin
            if (grades_seen != grades_taken) begin
                grades_seen = grades_taken;
                stall_left  = steady ? 0 : $urandom_range(0, 5);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Grade monitor: each grade taken is checked against the oldest one owed.
    always @(posedge aclk) begin : grade_monitor
        grade_t exp_g;
        if (aresetn && m_valid && m_ready) begin
            if (grade_q.size() == 0) begin
                note_mismatch($sformatf("grade %0d arrived with none owed", grades_taken));
            end else begin
                exp_g = grade_q.pop_front();
                if (m_level !== exp_g.level) begin
                    note_mismatch($sformatf("grade %0d: level %0d, expected %0d",
                                            grades_taken, m_level, exp_g.level));
                end
                if (m_speed_scale !== exp_g.speed_scale) begin
                    note_mismatch($sformatf("grade %0d: speed_scale %0d, expected %0d",
                                            grades_taken, m_speed_scale, exp_g.speed_scale));
                end
                if (m_reported_distance !== exp_g.distance) begin
                    note_mismatch($sformatf("grade %0d: distance %0d, expected %0d",
                                            grades_taken, m_reported_distance,
                                            exp_g.distance));
                end
                if (m_reading_valid !== exp_g.valid) begin
                    note_mismatch($sformatf("grade %0d: reading_valid %0d, expected %0d",
                                            grades_taken, m_reading_valid, exp_g.valid));
                end
            end
            grades_taken++;
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: directed sequences first, then random phases, each phase
    // with its own thresholds written while the block is idle.
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [DIST_W-1:0]  stop_v;
        logic [DIST_W-1:0]  slow_v;
        logic [DIST_W-1:0]  hyst_v;
        logic [SCALE_W-1:0] mscale_v;
        logic [TIME_W-1:0]  tmo_v;
        logic [DIST_W-1:0]  exit_v;
        logic [DIST_W-1:0]  rd_mm;
        logic               ok;
        logic [TIME_W-1:0]  clk_ms;
        int unsigned        lim;
        int unsigned        pick;
        int                 run_left;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset thresholds read back
        for (int r = 0; r <= int'(REG_INVALID_TIMEOUT); r++) begin
            check_reg(3'(r));
        end

        // Default thresholds: every level, band edges, the stop latch and
        // its hysteresis exit, an invalid run starting at time zero, and a
        // run whose timeout is crossed across the 32-bit wrap.
        add_reading(16'd2000, 1'b1, 32'd10);
        add_reading(16'd1001, 1'b1, 32'd20);
        add_reading(16'd1000, 1'b1, 32'd30);
        add_reading(16'd650,  1'b1, 32'd40);
        add_reading(16'd301,  1'b1, 32'd50);
        add_reading(16'd300,  1'b1, 32'd60);
        add_reading(16'd400,  1'b1, 32'd70);
        add_reading(16'd401,  1'b1, 32'd80);
        add_reading(16'd500,  1'b0, 32'd0);
        add_reading(INVALID_DISTANCE, 1'b1, 32'd499);
        add_reading(INVALID_DISTANCE, 1'b0, 32'd500);
        add_reading(16'hFFFE, 1'b1, 32'd510);
        add_reading(16'd0,    1'b1, 32'd520);
        add_reading(16'd123,  1'b0, 32'hFFFF_FFF0);
        add_reading(16'd123,  1'b0, 32'h0000_01E3);
        add_reading(16'd123,  1'b0, 32'h0000_01E4);
        add_reading(INVALID_DISTANCE, 1'b0, 32'hFFFF_FFFF);
        wait_idle();

        // Zero timeout and a minimum scale above full scale; unmapped
        // register writes must leave everything alone.
        write_reg(REG_INVALID_TIMEOUT, 32'd0);
        write_reg(REG_MINIMUM_SCALE, 32'hFFFF_FFFF);
        write_reg(3'd5, 32'd1);
        write_reg(3'd6, 32'hFFFF_FFFF);
        write_reg(3'd7, 32'h0000_0000);
        add_reading(16'd700,  1'b1, 32'd100);
        add_reading(16'd0,    1'b0, 32'd200);
        add_reading(16'd1200, 1'b1, 32'd300);
        wait_idle();

        // Stop equal to slow (no slow band), hysteresis sum wrapping to 64,
        // and the longest timeout reached at elapsed all ones.
        write_reg(REG_STOP_DISTANCE, 32'd500);
        write_reg(REG_SLOW_DISTANCE, 32'd500);
        write_reg(REG_HYST_DISTANCE, 32'd65100);
        write_reg(REG_MINIMUM_SCALE, 32'd0);
        write_reg(REG_INVALID_TIMEOUT, 32'hFFFF_FFFF);
        add_reading(16'd500, 1'b1, 32'd1);
        add_reading(16'd64,  1'b1, 32'd2);
        add_reading(16'd65,  1'b1, 32'd3);
        add_reading(16'd501, 1'b1, 32'd4);
        add_reading(16'd0,   1'b0, 32'd5);
        add_reading(16'd0,   1'b0, 32'd4);
        wait_idle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: begin
                    stop_v   = '1;
                    slow_v   = '1;
                    hyst_v   = '1;
                    mscale_v = '1;
                    tmo_v    = '1;
                end
                1: begin
                    stop_v   = '0;
                    slow_v   = '0;
                    hyst_v   = '0;
                    mscale_v = '0;
                    tmo_v    = '0;
                end
                2: begin
                    // hysteresis exit can wrap past 16 bits
                    stop_v   = 16'($urandom_range(30000, 65535));
                    slow_v   = 16'($urandom_range(int'(stop_v), 65535));
                    hyst_v   = 16'($urandom_range(30000, 65535));
                    mscale_v = 10'($urandom_range(0, 1023));
                    tmo_v    = $urandom_range(0, 800);
                end
                default: begin
                    stop_v   = 16'($urandom_range(0, 3000));
                    slow_v   = ($urandom_range(0, 5) == 0) ? stop_v
                             : 16'(stop_v + $urandom_range(1, 4000));
                    hyst_v   = 16'($urandom_range(0, 600));
                    mscale_v = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(1000, 1023))
                             : 10'($urandom_range(0, 1000));
                    tmo_v    = $urandom_range(0, 1500);
                    // now and then a threshold at one of its extremes, or
                    // the bands inverted
                    if ($urandom_range(0, 5) == 0) stop_v = $urandom_range(0, 1) ? '1 : '0;
                    if ($urandom_range(0, 5) == 0) slow_v = $urandom_range(0, 1) ? '1 : '0;
                    if ($urandom_range(0, 5) == 0) hyst_v = $urandom_range(0, 1) ? '1 : '0;
                    if ($urandom_range(0, 7) == 0) tmo_v  = $urandom_range(0, 1) ? '1 : '0;
                end
            endcase
            steady = (ph % 4 == 3);

            // upper bits carry junk that the registers must drop
            write_reg(REG_STOP_DISTANCE,   {16'($urandom), stop_v});
            write_reg(REG_SLOW_DISTANCE,   {16'($urandom), slow_v});
            write_reg(REG_HYST_DISTANCE,   {16'($urandom), hyst_v});
            write_reg(REG_MINIMUM_SCALE,   {22'($urandom), mscale_v});
            write_reg(REG_INVALID_TIMEOUT, tmo_v);
            if ($urandom_range(0, 2) == 0) begin
                write_reg(3'($urandom_range(5, 7)), $urandom);
            end

            exit_v = stop_v + hyst_v;
            lim    = (int'(slow_v) > 64934) ? 65534 : int'(slow_v) + 600;
            pick   = $urandom_range(0, 9);
            if (pick < 7) begin
                clk_ms = $urandom_range(0, 100000);
            end else if (pick < 9) begin
                clk_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
            end else begin
                clk_ms = $urandom;
            end
            run_left = 0;

            for (int i = 0; i < PHASE_ITEMS; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 88) begin
                    clk_ms = clk_ms + $urandom_range(0, 200);
                end else if (pick < 97) begin
                    clk_ms = clk_ms + $urandom_range(0, 3000);
                end else begin
                    clk_ms = $urandom;
                end

                pick = $urandom_range(0, 99);
                if (run_left == 0 && pick < 12) begin
                    run_left = $urandom_range(1, 10);
                end
                if (run_left > 0) begin
                    // invalid run: no echo, all-ones distance, or both
                    run_left--;
                    case ($urandom_range(0, 2))
                        0: begin rd_mm = 16'($urandom); ok = 1'b0; end
                        1: begin rd_mm = INVALID_DISTANCE; ok = 1'b1; end
                        default: begin rd_mm = INVALID_DISTANCE; ok = 1'b0; end
                    endcase
                end else if (pick > 96) begin
                    // loose noise
                    rd_mm = 16'($urandom);
                    ok    = 1'($urandom);
                end else begin
                    ok = 1'b1;
                    case ($urandom_range(0, 9))
                        0:       rd_mm = stop_v + 16'($urandom_range(0, 4)) - 16'd2;
                        1:       rd_mm = slow_v + 16'($urandom_range(0, 4)) - 16'd2;
                        2:       rd_mm = exit_v + 16'($urandom_range(0, 4)) - 16'd2;
                        3, 4, 5: rd_mm = 16'($urandom_range(0, lim));
                        6:       rd_mm = 16'($urandom);
                        7:       rd_mm = stop_v - 16'($urandom_range(0, 50));
                        8:       rd_mm = $urandom_range(0, 1) ? 16'd0 : 16'hFFFE;
                        default: rd_mm = slow_v + 16'($urandom_range(1, 3000));
                    endcase
                end
                add_reading(rd_mm, ok, clk_ms);
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (grade_q.size() != 0) begin
            note_mismatch($sformatf("%0d grades never arrived", grade_q.size()));
        end
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
